// ----- src/bertlv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bertlv_pkg
// Shared types and constants of the BER TLV field encoder.
// ----------------------------------------------------------------------------
package bertlv_pkg;

    localparam int BYTE_W        = 8;
    localparam int MAX_BYTES     = 7;
    localparam int STREAM_W      = MAX_BYTES * BYTE_W;
    localparam int COUNT_W       = 3;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [7:0] INTEGER_TAG   = 8'h02;
    localparam logic [7:0] TAG_TIMETICKS = 8'h43;
    localparam logic [7:0] TAG_IPADDR    = 8'h40;
    localparam logic [7:0] IPADDR_LEN    = 8'h04;
    localparam logic [7:0] LEN_LONG1     = 8'h81;
    localparam logic [7:0] LEN_LONG2     = 8'h82;
    localparam logic [7:0] SHORT_LEN_LIM = 8'h80;
    localparam logic [7:0] CONT_BIT      = 8'h80;

    typedef enum logic [2:0] {
        OP_INTEGER   = 3'd0,
        OP_TIMETICKS = 3'd1,
        OP_IPADDR    = 3'd2,
        OP_OID_FIRST = 3'd3,
        OP_OID_SUBID = 3'd4,
        OP_HEADER    = 3'd5
    } t_opcode;

    // First byte of the field sits in the top byte of stream.
    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [COUNT_W-1:0]  count;
    } t_entry;

endpackage
`default_nettype wire

// ----- src/bertlv_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bertlv_in_if / bertlv_out_if
// Request and byte channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bertlv_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [32:0] value;
    logic [1:0]         first_arc;
    logic [7:0]         tag;
    logic [15:0]        content_length;

    modport source (output valid, opcode, value, first_arc, tag, content_length,
                    input ready);
    modport sink   (input valid, opcode, value, first_arc, tag, content_length,
                    output ready);
endinterface

interface bertlv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ----- src/bertlv_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bertlv_front
// Accept requests, decode the opcode and build the byte stream of one field.
// ----------------------------------------------------------------------------
module bertlv_front (
    bertlv_in_if.sink              i_in,
    input  wire logic              i_full,
    output logic                   o_push,
    output bertlv_pkg::t_entry     o_entry
);

    logic [31:0] v;
    logic [2:0]  int_n;
    logic [31:0] int_left;
    logic [2:0]  u_n;
    logic        pad;
    logic [2:0]  tt_len;
    logic [39:0] tt_x;
    logic [39:0] tt_left;
    logic [6:0]  arc40;
    logic [31:0] w;
    logic [6:0]  g0, g1, g2, g3, g4;
    logic [2:0]  oid_k;
    logic        op_ok;

    assign v = i_in.value[31:0];

    always_comb begin
        if (v[31:23] != {9{v[31]}}) begin
            int_n = 3'd4;
        end else if (v[23:15] != {9{v[23]}}) begin
            int_n = 3'd3;
        end else if (v[15:7] != {9{v[15]}}) begin
            int_n = 3'd2;
        end else begin
            int_n = 3'd1;
        end
        case (int_n)
            3'd4:    int_left = v;
            3'd3:    int_left = {v[23:0], 8'h00};
            3'd2:    int_left = {v[15:0], 16'h0000};
            default: int_left = {v[7:0], 24'h000000};
        endcase
    end

    always_comb begin
        if (v[31:24] != 8'h00) begin
            u_n = 3'd4;
            pad = v[31];
        end else if (v[23:16] != 8'h00) begin
            u_n = 3'd3;
            pad = v[23];
        end else if (v[15:8] != 8'h00) begin
            u_n = 3'd2;
            pad = v[15];
        end else begin
            u_n = 3'd1;
            pad = v[7];
        end
        tt_len = u_n + {2'b00, pad};
        tt_x   = {8'h00, v};
        case (tt_len)
            3'd5:    tt_left = tt_x;
            3'd4:    tt_left = {tt_x[31:0], 8'h00};
            3'd3:    tt_left = {tt_x[23:0], 16'h0000};
            3'd2:    tt_left = {tt_x[15:0], 24'h000000};
            default: tt_left = {tt_x[7:0], 32'h00000000};
        endcase
    end

    always_comb begin
        if (bertlv_pkg::t_opcode'(i_in.opcode) == bertlv_pkg::OP_OID_FIRST) begin
            arc40 = {i_in.first_arc, 5'b00000} + {2'b00, i_in.first_arc, 3'b000};
        end else begin
            arc40 = 7'd0;
        end
        w  = v + {25'd0, arc40};
        g0 = w[6:0];
        g1 = w[13:7];
        g2 = w[20:14];
        g3 = w[27:21];
        g4 = {3'b000, w[31:28]};
        if (g4 != 7'd0) begin
            oid_k = 3'd5;
        end else if (g3 != 7'd0) begin
            oid_k = 3'd4;
        end else if (g2 != 7'd0) begin
            oid_k = 3'd3;
        end else if (g1 != 7'd0) begin
            oid_k = 3'd2;
        end else begin
            oid_k = 3'd1;
        end
    end

    always_comb begin
        op_ok          = 1'b1;
        o_entry.stream = '0;
        o_entry.count  = 3'd1;
        case (bertlv_pkg::t_opcode'(i_in.opcode))
            bertlv_pkg::OP_INTEGER: begin
                o_entry.stream = {bertlv_pkg::INTEGER_TAG, 5'b00000, int_n, int_left,
                                  8'h00};
                o_entry.count  = int_n + 3'd2;
            end
            bertlv_pkg::OP_TIMETICKS: begin
                o_entry.stream = {bertlv_pkg::TAG_TIMETICKS, 5'b00000, tt_len, tt_left};
                o_entry.count  = tt_len + 3'd2;
            end
            bertlv_pkg::OP_IPADDR: begin
                o_entry.stream = {bertlv_pkg::TAG_IPADDR, bertlv_pkg::IPADDR_LEN, v,
                                  8'h00};
                o_entry.count  = 3'd6;
            end
            bertlv_pkg::OP_OID_FIRST, bertlv_pkg::OP_OID_SUBID: begin
                case (oid_k)
                    3'd5: o_entry.stream = {1'b1, g4, 1'b1, g3, 1'b1, g2, 1'b1, g1,
                                            1'b0, g0, 16'h0000};
                    3'd4: o_entry.stream = {1'b1, g3, 1'b1, g2, 1'b1, g1, 1'b0, g0,
                                            24'h000000};
                    3'd3: o_entry.stream = {1'b1, g2, 1'b1, g1, 1'b0, g0,
                                            32'h00000000};
                    3'd2: o_entry.stream = {1'b1, g1, 1'b0, g0, 40'h0};
                    default: o_entry.stream = {1'b0, g0, 48'h0};
                endcase
                o_entry.count = oid_k;
            end
            bertlv_pkg::OP_HEADER: begin
                if (i_in.content_length < {8'h00, bertlv_pkg::SHORT_LEN_LIM}) begin
                    o_entry.stream = {i_in.tag, i_in.content_length[7:0], 40'h0};
                    o_entry.count  = 3'd2;
                end else if (i_in.content_length[15:8] == 8'h00) begin
                    o_entry.stream = {i_in.tag, bertlv_pkg::LEN_LONG1,
                                      i_in.content_length[7:0], 32'h00000000};
                    o_entry.count  = 3'd3;
                end else begin
                    o_entry.stream = {i_in.tag, bertlv_pkg::LEN_LONG2,
                                      i_in.content_length, 24'h000000};
                    o_entry.count  = 3'd4;
                end
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Drop unused opcodes: accept the beat, push nothing.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && op_ok;

endmodule
`default_nettype wire

// ----- src/bertlv_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bertlv_fifo
// Short show-ahead queue of encoded fields between front and back.
// ----------------------------------------------------------------------------
module bertlv_fifo #(
    parameter int DEPTH = bertlv_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  bertlv_pkg::t_entry      i_push_data,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output bertlv_pkg::t_entry      o_pop_data
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bertlv_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full     = (r_cnt == FULL_CNT);
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

// ----- src/bertlv_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bertlv_back
// Shift one queued field out a byte per beat, flag its final byte.
// ----------------------------------------------------------------------------
module bertlv_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    input  bertlv_pkg::t_entry      i_entry,
    output logic                    o_pop,
    bertlv_out_if.source            o_out
);

    localparam int BW = bertlv_pkg::BYTE_W;
    localparam int SW = bertlv_pkg::STREAM_W;

    logic [SW-1:0]                  r_stream, n_stream;
    logic [bertlv_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic                           beat;

    assign beat           = o_out.valid && o_out.ready;
    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_stream[SW-1 -: BW];
    assign o_out.last     = (r_cnt == 3'd1);
    assign o_pop          = !i_empty && ((r_cnt == '0) || (o_out.last && beat));

    always_comb begin
        n_stream = r_stream;
        n_cnt    = r_cnt;
        if (o_pop) begin
            n_stream = i_entry.stream;
            n_cnt    = i_entry.count;
        end else if (beat) begin
            n_stream = {r_stream[SW-BW-1:0], {BW{1'b0}}};
            n_cnt    = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stream <= n_stream;
    end

endmodule
`default_nettype wire

// ----- src/ber_tlv_field_encoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ber_tlv_field_encoder_top
// Encode one field request into its ASN.1 BER bytes, most significant first.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  i_in     in   opcode, value, first_arc, tag, content_length
//  o_out    out  out_byte, last (high on the final byte of a field)
//
//  A request is taken in any cycle while the field queue has room.
//  Each field leaves as 1 to 7 byte beats, one per cycle while o_out is ready,
//  with no gap while the next field is queued; the single byte shifter of
//  the back end sets the sustained rate. A request is held in the queue,
//  then in the shifter. Opcodes 6 and 7 are taken and give no beat.
//  Reset is synchronous; it empties the queue and the shifter.
// ----------------------------------------------------------------------------
module ber_tlv_field_encoder_top #(
    parameter int FIFO_DEPTH = bertlv_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    bertlv_in_if.sink       i_in,
    bertlv_out_if.source    o_out
);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    bertlv_pkg::t_entry push_entry;
    bertlv_pkg::t_entry pop_entry;

    bertlv_front u_front (
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    bertlv_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_entry),
        .i_pop       (pop),
        .o_full      (full),
        .o_empty     (empty),
        .o_pop_data  (pop_entry)
    );

    bertlv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ----- src/bertlv_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bertlv_checker
// Port-level checks of the BER TLV field encoder, bound to the top level.
// ----------------------------------------------------------------------------
module bertlv_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_beat_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output beat changed while stalled");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside a field");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output idle");

endmodule

bind ber_tlv_field_encoder_top bertlv_checker u_bertlv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ber_tlv_field_encoder_top: field requests go in over
// the request channel, each byte beat coming out is checked against an encoder
// kept here, with bursty requests and a stalling byte sink.
// ----------------------------------------------------------------------------
module tb;
    import bertlv_pkg::*;

    localparam logic [2:0] OP_SPARE_6   = 3'd6;
    localparam logic [2:0] OP_SPARE_7   = 3'd7;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         RANDOM_ITEMS = 300;
    localparam int         TAIL_CYCLES  = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef enum logic [1:0] {
        RX_FULL,
        RX_COIN,
        RX_EVERY_THIRD,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bertlv_in_if  req_if ();
    bertlv_out_if byte_if ();

    ber_tlv_field_encoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (byte_if)
    );

    t_beat      expected_beats[$];
    logic [7:0] enc_bytes[$];
    int         mismatch_count = 0;
    int         beats_checked  = 0;
    int         cycle_count    = 0;
    int         burst_left     = 0;
    int         op_count[8];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Encoder
    // ------------------------------------------------------------------------
    function automatic int unsigned_bytes(input logic [31:0] v);
        int n;
        n = 4;
        while (n > 1 && v[8*n-1 -: 8] == 8'h00)
            n--;
        return n;
    endfunction

    function automatic void push_length(input logic [15:0] len);
        if (len < 16'h0080) begin
            enc_bytes.push_back(len[7:0]);
        end else if (len <= 16'h00FF) begin
            enc_bytes.push_back(LEN_LONG1);
            enc_bytes.push_back(len[7:0]);
        end else begin
            enc_bytes.push_back(LEN_LONG2);
            enc_bytes.push_back(len[15:8]);
            enc_bytes.push_back(len[7:0]);
        end
    endfunction

    function automatic void push_base128(input logic [31:0] v);
        int          n;
        int          i;
        logic [31:0] sh;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 32'd0)
            n++;
        for (i = n - 1; i >= 0; i--) begin
            sh = v >> (7 * i);
            enc_bytes.push_back({(i != 0), sh[6:0]});
        end
    endfunction

    function automatic void predict_field(input logic [2:0] op, input logic [32:0] value,
                                          input logic [1:0] arc, input logic [7:0] tag,
                                          input logic [15:0] clen);
        logic [31:0] v;
        logic [31:0] sum;
        logic        neg;
        logic        pad;
        int          n;
        int          i;
        v = value[31:0];
        enc_bytes.delete();
        case (op)
            OP_INTEGER, OP_TIMETICKS: begin
                neg = (op == OP_INTEGER) && v[31];
                if (neg) begin
                    n = 4;
                    while (n > 1 && v[8*n-1 -: 8] == 8'hFF && v[8*n-9])
                        n--;
                end else begin
                    n = unsigned_bytes(v);
                end
                pad = !neg && v[8*n-1];
                enc_bytes.push_back(op == OP_INTEGER ? INTEGER_TAG : TAG_TIMETICKS);
                push_length(16'(n + int'(pad)));
                if (pad)
                    enc_bytes.push_back(8'h00);
                for (i = n - 1; i >= 0; i--)
                    enc_bytes.push_back(v[8*i +: 8]);
            end
            OP_IPADDR: begin
                enc_bytes.push_back(TAG_IPADDR);
                enc_bytes.push_back(IPADDR_LEN);
                for (i = 3; i >= 0; i--)
                    enc_bytes.push_back(v[8*i +: 8]);
            end
            OP_OID_FIRST: begin
                sum = {30'd0, arc} * 32'd40 + v;
                push_base128(sum);
            end
            OP_OID_SUBID: begin
                push_base128(v);
            end
            OP_HEADER: begin
                enc_bytes.push_back(tag);
                push_length(clen);
            end
            default: begin
            end
        endcase
        for (i = 0; i < enc_bytes.size(); i++)
            expected_beats.push_back('{data: enc_bytes[i], last: (i == enc_bytes.size() - 1)});
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [2:0] op, input logic [32:0] value,
                                input logic [1:0] arc, input logic [7:0] tag,
                                input logic [15:0] clen);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        req_if.opcode         = op;
        req_if.value          = value;
        req_if.first_arc      = arc;
        req_if.tag            = tag;
        req_if.content_length = clen;
        req_if.valid          = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        predict_field(op, value, arc, tag, clen);
        op_count[op]++;
        burst_left--;
    endtask

    function automatic logic [32:0] rand_value();
        logic [31:0] low;
        int          p;
        case ($urandom_range(0, 3))
            0: low = $urandom();
            1: low = $urandom_range(0, 300);
            2: begin
                p   = $urandom_range(0, 31);
                low = (32'd1 << p) + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default: low = -32'($urandom_range(1, 300));
        endcase
        return {(low[31] ? 1'($urandom_range(0, 1)) : 1'b0), low};
    endfunction

    function automatic logic [15:0] rand_length();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 127));
            1: return 16'($urandom_range(128, 255));
            2: return 16'($urandom_range(256, 65535));
            default: return 16'($urandom_range(0, 1) ? 16'h0080 : 16'h00FF);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", byte_if.out_byte, 8'h00);
            end else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (byte_if.out_byte !== want.data)
                    report_mismatch("out_byte", byte_if.out_byte, want.data);
                if (byte_if.last !== want.last)
                    report_mismatch("last", {7'd0, byte_if.last}, {7'd0, want.last});
            end
        end
    end

    t_rx_mode rx_mode  = RX_FULL;
    int       rx_left  = 0;
    int       rx_phase = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_FULL:        byte_if.ready = 1'b1;
            RX_COIN:        byte_if.ready = 1'($urandom_range(0, 1));
            RX_EVERY_THIRD: byte_if.ready = (rx_phase % 3) == 0;
            default:        byte_if.ready = ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, expected_beats.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_integer();
        send_request(OP_INTEGER, 33'h0_0000_0000, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_INTEGER, 33'h0_0000_007F, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_INTEGER, 33'h0_0000_0080, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_INTEGER, 33'h1_FFFF_FF80, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_INTEGER, 33'h1_FFFF_FF7F, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_INTEGER, 33'h0_7FFF_FFFF, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_INTEGER, 33'h1_8000_0000, 2'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic test_timeticks();
        send_request(OP_TIMETICKS, 33'h0_0000_0000, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_TIMETICKS, 33'h0_0000_0080, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_TIMETICKS, 33'h0_FFFF_FFFF, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_TIMETICKS, 33'h1_8000_0000, 2'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic test_ipaddr();
        send_request(OP_IPADDR, 33'h0_C0A8_0001, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_IPADDR, 33'h1_FFFF_FFFF, 2'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic test_oid();
        send_request(OP_OID_FIRST, 33'h0_0000_0003, 2'd1, 8'($urandom), 16'($urandom));
        send_request(OP_OID_FIRST, 33'h0_FFFF_FFFF, 2'd2, 8'($urandom), 16'($urandom));
        send_request(OP_OID_FIRST, 33'h0_0000_0005, 2'd3, 8'($urandom), 16'($urandom));
        send_request(OP_OID_SUBID, 33'h0_0000_007F, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_OID_SUBID, 33'h0_0000_0080, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_OID_SUBID, 33'h1_FFFF_FFFF, 2'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic test_header();
        send_request(OP_HEADER, 33'($urandom), 2'($urandom), 8'h00, 16'h007F);
        send_request(OP_HEADER, 33'($urandom), 2'($urandom), 8'h30, 16'h0080);
        send_request(OP_HEADER, 33'($urandom), 2'($urandom), 8'hA2, 16'h00FF);
        send_request(OP_HEADER, 33'($urandom), 2'($urandom), 8'h04, 16'h0100);
        send_request(OP_HEADER, 33'($urandom), 2'($urandom), 8'hFF, 16'hFFFF);
    endtask

    task automatic test_spare_opcodes();
        send_request(OP_SPARE_6, 33'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_HEADER, 33'($urandom), 2'($urandom), 8'h05, 16'h0000);
        send_request(OP_SPARE_7, 33'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic test_random_traffic(input int count);
        int          sent;
        logic [2:0]  op;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 15) == 0) begin
                op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            end else begin
                op = 3'($urandom_range(0, 5));
                sent++;
            end
            send_request(op, rand_value(), 2'($urandom_range(0, 2)), 8'($urandom),
                         rand_length());
        end
    endtask

    task automatic test_idle_drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        burst_left = $urandom_range(4, 12);
        send_request(OP_TIMETICKS, 33'h0_FFFF_FFFF, 2'($urandom), 8'($urandom), 16'($urandom));
        send_request(OP_OID_SUBID, 33'h0_FFFF_FFFF, 2'($urandom), 8'($urandom), 16'($urandom));
    endtask

    initial begin
        req_if.valid          = 1'b0;
        req_if.opcode         = 3'd0;
        req_if.value          = 33'd0;
        req_if.first_arc      = 2'd0;
        req_if.tag            = 8'd0;
        req_if.content_length = 16'd0;
        byte_if.ready         = 1'b0;
        foreach (op_count[i])
            op_count[i] = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_integer();
        test_timeticks();
        test_ipaddr();
        test_oid();
        test_header();
        test_spare_opcodes();
        test_random_traffic(RANDOM_ITEMS / 2);
        test_idle_drain();
        test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Requests: integer %0d, timeticks %0d, ipaddr %0d, oid first %0d",
                 op_count[OP_INTEGER], op_count[OP_TIMETICKS], op_count[OP_IPADDR],
                 op_count[OP_OID_FIRST]);
        $display("oid subid %0d, header %0d, spare %0d; %0d byte beats checked",
                 op_count[OP_OID_SUBID], op_count[OP_HEADER],
                 op_count[OP_SPARE_6] + op_count[OP_SPARE_7], beats_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
